// ===== hdl/dlvc_pkg.sv =====
// package for the display list vertex check block
// types, opcodes, verdict codes and decode helpers; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dlvc_pkg;

  localparam int unsigned SlotCount = 16;
  localparam int unsigned TriCount  = 4;
  localparam int unsigned VcountW   = 21;

  localparam logic [7:0] OpLoad   = 8'h04;
  localparam logic [7:0] OpQuad   = 8'hB1;
  localparam logic [7:0] OpEnd    = 8'hB8;
  localparam logic [7:0] OpSingle = 8'hBF;

  localparam logic [31:0] AddrMask = 32'h00FF_FFFF;

  typedef enum logic [1:0] {
    VERDICT_OK   = 2'd0,
    VERDICT_END  = 2'd1,
    VERDICT_BAD  = 2'd2,
    VERDICT_SKIP = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_END   = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_TRI   = 2'd3
  } kind_e;

  // decoded command as it travels from front to back
  typedef struct packed {
    logic                                first_of_list;
    kind_e                               kind;
    logic                                load_ok;
    logic [SlotCount-1:0]                load_mask;
    logic [TriCount-1:0]                 tri_act;
    logic [TriCount-1:0]                 tri_bad;
    logic [TriCount-1:0][SlotCount-1:0]  tri_mask;
  } cmd_t;

  // byte divided by ten via reciprocal multiply, exact for 0..255
  function automatic logic [4:0] div10(input logic [7:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'd205;
    return prod[15:11];
  endfunction

  function automatic logic [SlotCount-1:0] slot_bit(input logic [3:0] idx);
    return SlotCount'(1) << idx;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dlvc_ifs.sv =====
// channel interfaces for the display list vertex check block
// command, result and configuration channels; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface dlvc_cmd_if;
  logic        valid;
  logic        ready;
  logic        first_of_list;
  logic [31:0] word_high;
  logic [31:0] word_low;

  modport source (output valid, output first_of_list, output word_high, output word_low,
                  input ready);
  modport sink   (input valid, input first_of_list, input word_high, input word_low,
                  output ready);
endinterface

interface dlvc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       repair_needed;

  modport source (output valid, output verdict, output repair_needed, input ready);
  modport sink   (input valid, input verdict, input repair_needed, output ready);
endinterface

interface dlvc_cfg_if;
  logic        valid;
  logic        ready;
  logic [20:0] vertex_count;

  modport source (output valid, output vertex_count, input ready);
  modport sink   (input valid, input vertex_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/dlvc_front.sv =====
// front stage: accepts commands, decodes and pre-checks them into a register
// depends on dlvc_pkg and dlvc_cmd_if
`timescale 1ns / 1ps
`default_nettype none

module dlvc_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  dlvc_cmd_if.sink                         cmd_i,
  input  wire logic [dlvc_pkg::VcountW-1:0] vertex_count_i,
  output logic                             dec_valid_o,
  input  wire logic                        dec_ready_i,
  output dlvc_pkg::cmd_t                   dec_o
);

  logic           valid_q, valid_d;
  dlvc_pkg::cmd_t cmd_q, cmd_d;

  logic [7:0]  op;
  logic [3:0]  first;
  logic [4:0]  cnt;
  logic [5:0]  end_slot;
  logic [19:0] base;
  logic [21:0] base_end;
  logic [31:0] addr;
  logic [31:0] run_mask;
  logic [4:0]  q_a, q_b, q_c;

  assign cmd_i.ready = !valid_q || dec_ready_i;

  always_comb begin
    op       = cmd_i.word_high[31:24];
    first    = cmd_i.word_high[19:16];
    cnt      = 5'(cmd_i.word_high[23:20]) + 5'd1;
    end_slot = 6'(first) + 6'(cnt);
    addr     = cmd_i.word_low & dlvc_pkg::AddrMask;
    base     = addr[23:4];
    base_end = 22'(base) + 22'(cnt);
    run_mask = ((32'd1 << cnt) - 32'd1) << first;
    q_a      = dlvc_pkg::div10(cmd_i.word_low[23:16]);
    q_b      = dlvc_pkg::div10(cmd_i.word_low[15:8]);
    q_c      = dlvc_pkg::div10(cmd_i.word_low[7:0]);

    cmd_d               = '0;
    cmd_d.first_of_list = cmd_i.first_of_list;
    cmd_d.load_mask     = run_mask[dlvc_pkg::SlotCount-1:0];
    cmd_d.load_ok       = (end_slot <= 6'(dlvc_pkg::SlotCount)) && (addr[3:0] == 4'd0)
                          && (base_end <= 22'(vertex_count_i));
    unique case (op)
      dlvc_pkg::OpEnd:  cmd_d.kind = dlvc_pkg::KIND_END;
      dlvc_pkg::OpLoad: cmd_d.kind = dlvc_pkg::KIND_LOAD;
      dlvc_pkg::OpSingle: begin
        cmd_d.kind        = dlvc_pkg::KIND_TRI;
        cmd_d.tri_act[0]  = 1'b1;
        cmd_d.tri_bad[0]  = q_a[4] | q_b[4] | q_c[4];
        cmd_d.tri_mask[0] = dlvc_pkg::slot_bit(q_a[3:0]) | dlvc_pkg::slot_bit(q_b[3:0])
                            | dlvc_pkg::slot_bit(q_c[3:0]);
      end
      dlvc_pkg::OpQuad: begin
        cmd_d.kind = dlvc_pkg::KIND_TRI;
        for (int t = 0; t < dlvc_pkg::TriCount; t++) begin
          cmd_d.tri_act[t]  = (cmd_i.word_low[t*8 +: 8] != 8'd0)
                              || (cmd_i.word_high[t*4 +: 4] != 4'd0);
          cmd_d.tri_mask[t] = dlvc_pkg::slot_bit(cmd_i.word_low[t*8 +: 4])
                              | dlvc_pkg::slot_bit(cmd_i.word_low[t*8+4 +: 4])
                              | dlvc_pkg::slot_bit(cmd_i.word_high[t*4 +: 4]);
        end
      end
      default: cmd_d.kind = dlvc_pkg::KIND_OTHER;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.ready) begin
      valid_d = cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      cmd_q <= cmd_d;
    end
  end

  assign dec_valid_o = valid_q;
  assign dec_o       = cmd_q;

endmodule

`default_nettype wire

// ===== hdl/dlvc_queue.sv =====
// short queue between front and back stages
// depends on dlvc_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module dlvc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire dlvc_pkg::cmd_t push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output dlvc_pkg::cmd_t      pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  dlvc_pkg::cmd_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dlvc_back.sv =====
// back stage: applies decoded commands to the slot masks and registers the result
// depends on dlvc_pkg and dlvc_res_if
`timescale 1ns / 1ps
`default_nettype none

module dlvc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  wire dlvc_pkg::cmd_t cmd_i,
  dlvc_res_if.source          res_o
);

  localparam int unsigned N = dlvc_pkg::SlotCount;

  logic [N-1:0]       valid_slots_q, valid_slots_d;
  logic [N-1:0]       last_slots_q, last_slots_d;
  logic               finished_q, finished_d;
  logic               out_valid_q;
  dlvc_pkg::verdict_e verdict_q, verdict_d;
  logic               repair_q, repair_d;

  logic         take;
  logic         fin;
  logic [N-1:0] vs, ls;
  logic         any_bad, any_rep;

  assign cmd_ready_o = !out_valid_q || res_o.ready;
  assign take        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    fin = cmd_i.first_of_list ? 1'b0 : finished_q;
    vs  = cmd_i.first_of_list ? '0 : valid_slots_q;
    ls  = cmd_i.first_of_list ? '0 : last_slots_q;

    any_bad = 1'b0;
    any_rep = 1'b0;
    for (int t = 0; t < dlvc_pkg::TriCount; t++) begin
      if (cmd_i.tri_act[t]) begin
        any_bad = any_bad | cmd_i.tri_bad[t] | ((cmd_i.tri_mask[t] & ~vs) != '0);
        any_rep = any_rep | ((cmd_i.tri_mask[t] & ~ls) != '0);
      end
    end

    valid_slots_d = vs;
    last_slots_d  = ls;
    finished_d    = fin;
    verdict_d     = dlvc_pkg::VERDICT_OK;
    repair_d      = 1'b0;

    if (fin) begin
      verdict_d = dlvc_pkg::VERDICT_SKIP;
    end else begin
      unique case (cmd_i.kind)
        dlvc_pkg::KIND_END: begin
          verdict_d  = dlvc_pkg::VERDICT_END;
          finished_d = 1'b1;
        end
        dlvc_pkg::KIND_LOAD: begin
          if (cmd_i.load_ok) begin
            last_slots_d  = cmd_i.load_mask;
            valid_slots_d = vs | cmd_i.load_mask;
          end else begin
            verdict_d  = dlvc_pkg::VERDICT_BAD;
            finished_d = 1'b1;
          end
        end
        dlvc_pkg::KIND_TRI: begin
          if (any_bad) begin
            verdict_d  = dlvc_pkg::VERDICT_BAD;
            finished_d = 1'b1;
          end else begin
            repair_d = any_rep;
          end
        end
        default: verdict_d = dlvc_pkg::VERDICT_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_slots_q <= '0;
      last_slots_q  <= '0;
      finished_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_ready_o) begin
        out_valid_q <= cmd_valid_i;
      end
      if (take) begin
        valid_slots_q <= valid_slots_d;
        last_slots_q  <= last_slots_d;
        finished_q    <= finished_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      verdict_q <= verdict_d;
      repair_q  <= repair_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.verdict       = verdict_q;
  assign res_o.repair_needed = repair_q;

endmodule

`default_nettype wire

// ===== hdl/display_list_vertex_check_core.sv =====
// display list vertex check, top level
// depends on dlvc_pkg, dlvc_ifs, dlvc_front, dlvc_queue and dlvc_back
//
// usage:
// - cmd_i carries one 64-bit display-list command per beat (first_of_list,
//   word_high, word_low); res_o returns one beat per command with the
//   verdict (ok, end, invalid, skipped) and the repair flag
// - cfg_i writes the vertex count; it is always ready and is meant to be
//   written only while no command is in flight
// - throughput is one command per cycle while res_o does not stall; each command
//   loads the decode register, then the queue, then the result register
// - the front decodes a command and does the load and index checks; the
//   back owns the valid / last-load slot masks and the finished flag
// - when res_o stalls, the result register holds, the back stops popping,
//   and the queue plus the decode register absorb further commands before
//   cmd_i.ready drops
// - reset clears both slot masks, the finished flag, the vertex count and
//   all valid flags; the first list is treated as already open
`timescale 1ns / 1ps
`default_nettype none

module display_list_vertex_check_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dlvc_cmd_if.sink   cmd_i,
  dlvc_cfg_if.sink   cfg_i,
  dlvc_res_if.source res_o
);

  // vertex count register, written through the config channel
  logic [dlvc_pkg::VcountW-1:0] vertex_count_q;

  // front -> queue
  logic           dec_valid, dec_ready;
  dlvc_pkg::cmd_t dec_cmd;

  // queue -> back
  logic           q_valid, q_ready;
  dlvc_pkg::cmd_t q_cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= '0;
    end else if (cfg_i.valid) begin
      vertex_count_q <= cfg_i.vertex_count;
    end
  end

  // decode and pre-check
  dlvc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .vertex_count_i (vertex_count_q),
    .dec_valid_o    (dec_valid),
    .dec_ready_i    (dec_ready),
    .dec_o          (dec_cmd)
  );

  // decoupling queue
  dlvc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (dec_valid),
    .push_ready_o (dec_ready),
    .push_data_i  (dec_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  // mask state and result register
  dlvc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ===== test/tb_display_list_vertex_check_core.sv =====
// testbench for display_list_vertex_check_core: directed and random command streams
// checked beat by beat against a behavioral model of the slot masks and list state
// depends on dlvc_pkg, dlvc_ifs and the core itself
`timescale 1ns / 1ps

module tb_display_list_vertex_check_core;

  // no beat on any channel for this many cycles means the block hung
  localparam int unsigned StallLimit = 2000;
  // leave some margin at the end
  localparam int unsigned TailCycles = 8;

  // how one triangle fits the cache, ordered so the worst one wins
  typedef enum int {
    TRI_FITS,
    TRI_NEEDS_REPAIR,
    TRI_MISSING
  } tri_fit_e;

  typedef struct packed {
    dlvc_pkg::verdict_e verdict;
    logic               repair;
  } outcome_t;

  logic clk;
  logic rst_n;

  dlvc_cmd_if cmd_ch ();
  dlvc_cfg_if cfg_ch ();
  dlvc_res_if res_ch ();

  display_list_vertex_check_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_ch),
    .cfg_i  (cfg_ch),
    .res_o  (res_ch)
  );

  // model state: vertex cache masks, list status and the vertex count register
  logic [15:0] slots_loaded     = '0;
  logic [15:0] slots_last_load  = '0;
  logic        list_done        = 1'b0;
  logic [20:0] model_vertex_count = '0;

  // outcomes predicted for accepted commands, oldest first
  outcome_t pending_outcomes[$];

  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  // while set, neither side idles nor stalls
  bit          quiet_stretch = 1'b0;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // behavioral model
  // ---------------------------------------------------------------------------

  // every index must be a loaded slot; slots outside the last load want repair
  function automatic tri_fit_e classify_triangle(input int unsigned a, input int unsigned b,
                                                 input int unsigned c);
    logic [15:0] used;
    if (a >= 16 || b >= 16 || c >= 16) return TRI_MISSING;
    used = (16'd1 << a) | (16'd1 << b) | (16'd1 << c);
    if ((used & slots_loaded) != used) return TRI_MISSING;
    if ((used & slots_last_load) != used) return TRI_NEEDS_REPAIR;
    return TRI_FITS;
  endfunction

  // advances the model by one command and returns the result it should produce
  function automatic outcome_t predict_outcome(input logic first, input logic [31:0] hi,
                                               input logic [31:0] lo);
    outcome_t    res;
    logic [7:0]  op;
    int unsigned first_slot;
    int unsigned cnt;
    logic [31:0] addr;
    int unsigned base;
    tri_fit_e    worst;
    tri_fit_e    fit;
    int          t;
    res.verdict = dlvc_pkg::VERDICT_OK;
    res.repair  = 1'b0;
    op = hi[31:24];
    if (first) begin
      slots_loaded    = '0;
      slots_last_load = '0;
      list_done       = 1'b0;
    end
    if (list_done) begin
      res.verdict = dlvc_pkg::VERDICT_SKIP;
    end else if (op == dlvc_pkg::OpEnd) begin
      res.verdict = dlvc_pkg::VERDICT_END;
      list_done   = 1'b1;
    end else if (op == dlvc_pkg::OpLoad) begin
      first_slot = int'(hi[19:16]);
      cnt        = int'(hi[23:20]) + 1;
      addr       = lo & dlvc_pkg::AddrMask;
      base       = int'(addr >> 4);
      if (first_slot + cnt > 16 || addr[3:0] != 4'h0
          || base + cnt > int'(model_vertex_count)) begin
        res.verdict = dlvc_pkg::VERDICT_BAD;
        list_done   = 1'b1;
      end else begin
        slots_last_load = 16'(((32'd1 << cnt) - 32'd1) << first_slot);
        slots_loaded    = slots_loaded | slots_last_load;
      end
    end else if (op == dlvc_pkg::OpSingle || op == dlvc_pkg::OpQuad) begin
      worst = TRI_FITS;
      if (op == dlvc_pkg::OpSingle) begin
        worst = classify_triangle(lo[23:16] / 10, lo[15:8] / 10, lo[7:0] / 10);
      end else begin
        for (t = 0; t < dlvc_pkg::TriCount; t++) begin
          // all-zero triangles are padding; stop once the list is rejected
          if (worst != TRI_MISSING
              && {lo[8*t +: 4], lo[8*t+4 +: 4], hi[4*t +: 4]} != 12'h000) begin
            fit = classify_triangle(lo[8*t +: 4], lo[8*t+4 +: 4], hi[4*t +: 4]);
            if (fit > worst) worst = fit;
          end
        end
      end
      if (worst == TRI_MISSING) begin
        res.verdict = dlvc_pkg::VERDICT_BAD;
        list_done   = 1'b1;
      end else begin
        res.repair = (worst == TRI_NEEDS_REPAIR);
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // drives one command beat; called and returns at a falling edge, valid left high
  task automatic send_cmd(input logic first, input logic [31:0] hi, input logic [31:0] lo);
    if (!quiet_stretch && $urandom_range(0, 99) < 3) begin
      cmd_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    cmd_ch.valid         = 1'b1;
    cmd_ch.first_of_list = first;
    cmd_ch.word_high     = hi;
    cmd_ch.word_low      = lo;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    pending_outcomes.push_back(predict_outcome(first, hi, lo));
    @(negedge clk);
  endtask

  // stops sending and waits for every outstanding result
  task automatic drain_results();
    cmd_ch.valid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  // the register may only change with nothing in flight
  task automatic write_vertex_count(input logic [20:0] value);
    drain_results();
    cfg_ch.valid        = 1'b1;
    cfg_ch.vertex_count = value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    model_vertex_count = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // command builders for the random part
  // ---------------------------------------------------------------------------

  // mostly a slot the cache holds, so triangles get past the first checks
  function automatic logic [3:0] pick_slot(input bit from_cache);
    int start;
    int i;
    start = $urandom_range(0, 15);
    if (from_cache && slots_loaded != '0) begin
      for (i = 0; i < 16; i++) begin
        if (slots_loaded[(start + i) % 16]) return 4'((start + i) % 16);
      end
    end
    return 4'(start);
  endfunction

  // a sane load fits the slot range, is aligned and stays inside the vertex count if it is at least cnt
  function automatic logic [63:0] make_load(input bit sane);
    int unsigned first_slot;
    int unsigned cnt;
    int unsigned top_base;
    int unsigned base;
    logic [3:0]  low_nibble;
    first_slot = $urandom_range(0, 15);
    low_nibble = 4'h0;
    if (sane) begin
      cnt = $urandom_range(1, 16 - first_slot);
      if (int'(model_vertex_count) >= cnt) begin
        top_base = model_vertex_count - cnt;
        if (top_base > 32'hF_FFFF) top_base = 32'hF_FFFF;
        base = ($urandom_range(0, 3) == 0) ? top_base : $urandom_range(0, top_base);
      end else begin
        base = $urandom_range(0, 15);
      end
    end else begin
      cnt  = $urandom_range(1, 16);
      base = $urandom_range(0, 32'hF_FFFF);
      if ($urandom_range(0, 1) == 0) low_nibble = 4'($urandom);
    end
    return {dlvc_pkg::OpLoad, 4'(cnt - 1), 4'(first_slot), 16'($urandom),
            8'($urandom), 20'(base), low_nibble};
  endfunction

  function automatic logic [63:0] make_single();
    logic [7:0] idx_bytes [3];
    int         k;
    for (k = 0; k < 3; k++) begin
      if ($urandom_range(0, 29) == 0) idx_bytes[k] = 8'($urandom_range(160, 255));
      else idx_bytes[k] = 8'(pick_slot($urandom_range(0, 19) != 0) * 10
                             + $urandom_range(0, 9));
    end
    return {dlvc_pkg::OpSingle, 24'($urandom), 8'($urandom),
            idx_bytes[0], idx_bytes[1], idx_bytes[2]};
  endfunction

  function automatic logic [63:0] make_quad();
    logic [31:0] hi;
    logic [31:0] lo;
    int          t;
    hi = {dlvc_pkg::OpQuad, 8'($urandom), 16'h0000};
    lo = '0;
    for (t = 0; t < dlvc_pkg::TriCount; t++) begin
      if ($urandom_range(0, 3) != 0) begin
        lo[8*t +: 4]   = pick_slot($urandom_range(0, 19) != 0);
        lo[8*t+4 +: 4] = pick_slot($urandom_range(0, 19) != 0);
        hi[4*t +: 4]   = pick_slot($urandom_range(0, 19) != 0);
      end
    end
    return {hi, lo};
  endfunction

  function automatic logic [63:0] make_other();
    logic [7:0] op;
    do op = 8'($urandom);
    while (op == dlvc_pkg::OpLoad || op == dlvc_pkg::OpQuad || op == dlvc_pkg::OpEnd
           || op == dlvc_pkg::OpSingle);
    return {op, 24'($urandom), 32'($urandom)};
  endfunction

  // raw words, half of them forced onto one of the decoded opcodes
  function automatic logic [63:0] make_noise();
    logic [63:0] word;
    word = {32'($urandom), 32'($urandom)};
    case ($urandom_range(0, 7))
      0: word[63:56] = dlvc_pkg::OpLoad;
      1: word[63:56] = dlvc_pkg::OpQuad;
      2: word[63:56] = dlvc_pkg::OpEnd;
      3: word[63:56] = dlvc_pkg::OpSingle;
      default: ;
    endcase
    return word;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // out of reset the first list is already open and the vertex count is zero
  task automatic test_open_list_from_reset();
    send_cmd(1'b0, 32'h0000_0000, 32'h0000_0000);
    // quad made only of padding triangles passes
    send_cmd(1'b0, {dlvc_pkg::OpQuad, 24'h00_0000}, 32'h0000_0000);
    // nothing is loaded yet, so any real triangle kills the list
    send_cmd(1'b0, {dlvc_pkg::OpSingle, 24'h00_0000}, 32'h0000_0000);
    send_cmd(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_load_checks();
    write_vertex_count(21'd16);
    send_cmd(1'b1, {dlvc_pkg::OpLoad, 4'hF, 4'h0, 16'hFFFF}, 32'h0000_0000);
    // slot range 8..16 overruns the cache
    send_cmd(1'b0, {dlvc_pkg::OpLoad, 4'h8, 4'h8, 16'h0000}, 32'h0000_0000);
    // misaligned address
    send_cmd(1'b1, {dlvc_pkg::OpLoad, 4'h0, 4'h0, 16'h0000}, 32'h0000_0008);
    // last vertex exactly at the count; address top byte is not part of it
    send_cmd(1'b1, {dlvc_pkg::OpLoad, 4'h0, 4'hF, 16'h0000}, 32'hFF00_00F0);
    // one past the count
    send_cmd(1'b0, {dlvc_pkg::OpLoad, 4'h1, 4'h0, 16'h0000}, 32'h0000_00F0);
    send_cmd(1'b1, {dlvc_pkg::OpEnd, 24'hFF_FFFF}, 32'hFFFF_FFFF);
    send_cmd(1'b0, {dlvc_pkg::OpLoad, 4'h0, 4'h0, 16'h0000}, 32'h0000_0000);
  endtask

  task automatic test_triangle_checks();
    send_cmd(1'b1, {dlvc_pkg::OpLoad, 4'hF, 4'h0, 16'h0000}, 32'h0000_0000);
    // last load now covers slots 4 and 5 only
    send_cmd(1'b0, {dlvc_pkg::OpLoad, 4'h1, 4'h4, 16'h0000}, 32'h0000_0000);
    send_cmd(1'b0, {dlvc_pkg::OpSingle, 24'h00_0000}, {8'hFF, 8'd40, 8'd59, 8'd41});
    // byte 159 still maps to slot 15, loaded earlier but not last
    send_cmd(1'b0, {dlvc_pkg::OpSingle, 24'h00_0000}, {8'h00, 8'd0, 8'd150, 8'd159});
    // padding in triangles 0 and 2, real triangles in 1 and 3
    send_cmd(1'b0, {dlvc_pkg::OpQuad, 8'h00, 16'h5040}, 32'h4500_5400);
    send_cmd(1'b0, {dlvc_pkg::OpQuad, 8'hFF, 16'h0005}, 32'h0000_004F);
    // byte 160 is index 16
    send_cmd(1'b0, {dlvc_pkg::OpSingle, 24'h00_0000}, {8'h00, 8'd0, 8'd0, 8'd160});
    send_cmd(1'b1, {dlvc_pkg::OpLoad, 4'h0, 4'h2, 16'h0000}, 32'h0000_0000);
    // slot 3 was never loaded in this list
    send_cmd(1'b0, {dlvc_pkg::OpQuad, 8'h00, 16'h0003}, 32'h0000_0022);
  endtask

  task automatic test_vertex_count_extremes();
    write_vertex_count(21'd0);
    send_cmd(1'b1, {dlvc_pkg::OpLoad, 4'h0, 4'h0, 16'h0000}, 32'h0000_0000);
    write_vertex_count(21'd1048576);
    send_cmd(1'b1, {dlvc_pkg::OpLoad, 4'h0, 4'h0, 16'h0000}, 32'h00FF_FFF0);
    send_cmd(1'b0, {dlvc_pkg::OpLoad, 4'h1, 4'h0, 16'h0000}, 32'h00FF_FFF0);
    write_vertex_count(21'h1F_FFFF);
    send_cmd(1'b1, {dlvc_pkg::OpLoad, 4'hF, 4'h0, 16'h0000}, 32'hFFFF_FFF0);
    send_cmd(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // mostly well-formed lists: a load, a run of mixed commands, usually an end
  task automatic random_lists(input int n_items);
    int          sent;
    int          span;
    int          roll;
    logic        first;
    logic [63:0] word;
    sent = 0;
    while (sent < n_items) begin
      word = make_load($urandom_range(0, 9) != 0);
      send_cmd($urandom_range(0, 9) != 0, word[63:32], word[31:0]);
      sent++;
      span = $urandom_range(2, 12);
      repeat (span) begin
        roll  = $urandom_range(0, 99);
        first = 1'b0;
        if (roll < 15) word = make_load($urandom_range(0, 9) != 0);
        else if (roll < 45) word = make_single();
        else if (roll < 75) word = make_quad();
        else if (roll < 83) word = make_other();
        else if (roll < 93) begin
          word  = make_noise();
          first = ($urandom_range(0, 3) == 0);
        end else begin
          // restart mid-list
          word  = make_load(1'b1);
          first = 1'b1;
        end
        send_cmd(first, word[63:32], word[31:0]);
        sent++;
      end
      if ($urandom_range(0, 4) != 0) begin
        send_cmd(1'b0, {dlvc_pkg::OpEnd, 24'($urandom)}, 32'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random_lists();
    logic [20:0] counts [6];
    int          phase;
    counts = '{21'd16, 21'd1048576, 21'h1F_FFFF, 21'd3, 21'd0, 21'd0};
    counts[5] = 21'($urandom_range(1, 64));
    for (phase = 0; phase < 6; phase++) begin
      write_vertex_count(counts[phase]);
      // one phase runs back to back with no gaps or stalls
      quiet_stretch = (phase == 2);
      random_lists(75);
    end
    quiet_stretch = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random backpressure and the check of each beat
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    res_ch.ready = quiet_stretch || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        log_failure($sformatf("result %0d with no command pending: verdict %0d repair %0b",
                              results_seen, res_ch.verdict, res_ch.repair_needed));
      end else begin
        want = pending_outcomes.pop_front();
        if (res_ch.verdict !== want.verdict || res_ch.repair_needed !== want.repair) begin
          log_failure($sformatf("result %0d: expected verdict %s repair %0b, got %0d / %0b",
                                results_seen, want.verdict.name(), want.repair,
                                res_ch.verdict, res_ch.repair_needed));
        end
      end
    end
  end

  // hang detection: any beat on any channel restarts the count
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("display_list_vertex_check_core regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    cmd_ch.valid         = 1'b0;
    cmd_ch.first_of_list = 1'b0;
    cmd_ch.word_high     = '0;
    cmd_ch.word_low      = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.vertex_count  = '0;
    res_ch.ready         = 1'b0;
    rst_n                = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_open_list_from_reset();
    test_load_checks();
    test_triangle_checks();
    test_vertex_count_extremes();
    test_random_lists();

    // let the last results drain, then watch for stray beats
    drain_results();
    repeat (TailCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("display_list_vertex_check_core regression: pass");
    end else begin
      $display("display_list_vertex_check_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dlvc_pkg.sv
hdl/dlvc_ifs.sv
hdl/dlvc_front.sv
hdl/dlvc_queue.sv
hdl/dlvc_back.sv
hdl/display_list_vertex_check_core.sv
test/tb_display_list_vertex_check_core.sv
